[rtl/core/four_tone_chord_synth_defines.svh]
// ----------------------------------------------------------------------------
// Four-tone chord synthesizer assertion macros
// Shared property forms used by the synthesizer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef FOUR_TONE_CHORD_SYNTH_DEFINES_SVH
`define FOUR_TONE_CHORD_SYNTH_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define FCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define FCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-tone chord synthesizer package
// Shared widths, register indexes, reset tuning words, control types and the
// quarter-wave sine generator used to fill the lookup tables at elaboration.
// ----------------------------------------------------------------------------
package fcs_pkg;

    localparam int TONES       = 4;
    localparam int SINE_W      = 15;   // quarter-wave magnitude, Q1.15 without sign
    localparam int SAMPLE_W    = 16;
    localparam int STEP_W      = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int SUM_W       = SINE_W + 3;

    localparam logic [CFG_INDEX_W-1:0] REG_TONE_STEP_0 = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TONE_STEP_1 = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TONE_STEP_2 = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TONE_STEP_3 = 8'd3;

    // C4, E4, G4 and C5 at a 44.1 kHz frame rate.
    localparam logic [STEP_W-1:0] TONE_STEP_RESET [TONES] = '{
        32'd25479577, 32'd32102218, 32'd38176514, 32'd50960131
    };

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned SINE_MAX    = 64'd32767;

    typedef logic signed [SINE_W:0] sine_t;

    typedef struct packed {
        logic advance;
        logic restart;
    } tone_ctrl_t;

    // Floor quotient by restoring long division, one bit per loop pass.
    // Only evaluated while building constant tables.
    function automatic longint unsigned floor_div(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | (64'd1 << b);
            end
        end
        return quo;
    endfunction

    // sin(pi/2 * j / 2^qbits) in Q1.15 via a Taylor series in Horner form.
    // Only evaluated while building constant tables.
    function automatic logic [SINE_W-1:0] quarter_sine(input longint unsigned j,
                                                       input int unsigned qbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        longint unsigned d;
        longint unsigned jj;
        jj = j;
        if (jj > (64'd1 << qbits))
        begin
            jj = 64'd1 << qbits;
        end
        x  = (jj * HALF_PI_Q30) >> qbits;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        for (int k = 7; k >= 1; k--)
        begin
            d = longint'(2 * k) * longint'(2 * k + 1);
            t = ONE_Q30 - floor_div((x2 * t) >> 30, d);
        end
        s = (x * t) >> 30;
        v = (SINE_MAX * s + (ONE_Q30 >> 1)) >> 30;
        if (v > SINE_MAX)
        begin
            v = SINE_MAX;
        end
        return SINE_W'(v);
    endfunction

endpackage

[rtl/core/four_tone_chord_synth.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-tone chord synthesizer
// Direct digital synthesis of a four-note chord, one stereo frame per input.
// ----------------------------------------------------------------------------
// Each transaction on the input stream produces one stereo frame on the output
// stream: the sum of four sine tones at a quarter of full scale, the same
// 16-bit sample on left and right. Setting restart zeroes all four phases
// before the frame, so that frame is silent. The block takes one frame per
// clock while the output is not back-pressured; an accepted frame passes first
// through the registered quarter-wave ROM read in each tone channel, then the
// mixer register. The tuning words sit at indexes 0 to 3 of the configuration
// channel, which is always ready; writes to other indexes are dropped.
`include "four_tone_chord_synth_defines.svh"
module four_tone_chord_synth #(
    parameter int TABLE_BITS = 10,
    parameter int PHASE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [0] restart
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // [15:0] left_sample,
                                                             // [31:16] right_sample
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fcs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fcs_pkg::STEP_W-1:0]        cfg_data
);
    import fcs_pkg::*;

    logic [PHASE_BITS-1:0] step_reg [TONES];
    logic [TONES-1:0]      step_we;
    logic                  valid_a_reg;
    logic                  valid_a_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  a_ready;
    logic                  b_ready;
    logic                  in_accept;
    logic                  mix_load;
    tone_ctrl_t            tone_ctrl;
    sine_t                 tone_sine [TONES];
    logic [SAMPLE_W-1:0]   sample;

    // Configuration decode.
    always_comb
    begin
        unique case (cfg_index)
            REG_TONE_STEP_0: step_we = 4'b0001;
            REG_TONE_STEP_1: step_we = 4'b0010;
            REG_TONE_STEP_2: step_we = 4'b0100;
            REG_TONE_STEP_3: step_we = 4'b1000;
            default:         step_we = 4'b0000;
        endcase
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TONES; i++)
            begin
                step_reg[i] <= PHASE_BITS'(TONE_STEP_RESET[i]);
            end
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < TONES; i++)
            begin
                if (step_we[i])
                begin
                    step_reg[i] <= cfg_data[PHASE_BITS-1:0];
                end
            end
        end
    end

    // Two-stage pipeline; each stage fills whenever its successor can move.
    always_comb
    begin
        b_ready        = !out_valid_reg || m_axis_tready;
        a_ready        = !valid_a_reg || b_ready;
        in_accept      = s_axis_tvalid && a_ready;
        mix_load       = valid_a_reg && b_ready;
        valid_a_next   = a_ready ? s_axis_tvalid : valid_a_reg;
        out_valid_next = b_ready ? valid_a_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg   <= valid_a_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign tone_ctrl.advance = in_accept;
    assign tone_ctrl.restart = s_axis_tdata[0];

    for (genvar g = 0; g < TONES; g++)
    begin : gen_tone
        fcs_tone #(
            .TABLE_BITS (TABLE_BITS),
            .PHASE_BITS (PHASE_BITS)
        ) u_tone (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (tone_ctrl),
            .step  (step_reg[g]),
            .sine  (tone_sine[g])
        );
    end

    fcs_mixer u_mixer (
        .clk    (clk),
        .load   (mix_load),
        .sines  (tone_sine),
        .sample (sample)
    );

    assign s_axis_tready = a_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {sample, sample};

    `FCS_ASSERT_NEXT(a_restart_silent,
        s_axis_tvalid && s_axis_tready && s_axis_tdata[0],
        valid_a_reg && tone_sine[0] == '0 && tone_sine[1] == '0
            && tone_sine[2] == '0 && tone_sine[3] == '0,
        "restart frame did not read phase zero on every tone")

    `FCS_ASSERT_NEXT(a_stage_hold,
        valid_a_reg && !b_ready,
        valid_a_reg && $stable(tone_sine[0]) && $stable(tone_sine[1])
            && $stable(tone_sine[2]) && $stable(tone_sine[3]),
        "stalled tone stage lost or changed its samples")

    `FCS_ASSERT_SAME(a_ready_when_empty,
        !out_valid_reg,
        s_axis_tready,
        "input stalled while the output register was empty")

endmodule

[rtl/core/fcs_sine_rom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quarter-wave sine ROM
// Holds sin over one quadrant, endpoints included, with a registered read.
// ----------------------------------------------------------------------------
module fcs_sine_rom #(
    parameter int QUARTER_BITS = 8
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [QUARTER_BITS:0]     addr,
    output logic [fcs_pkg::SINE_W-1:0] data
);
    import fcs_pkg::*;

    localparam int DEPTH = (1 << QUARTER_BITS) + 1;

    typedef logic [SINE_W-1:0] rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < DEPTH; i++)
        begin
            r[i] = quarter_sine(longint'(i), QUARTER_BITS);
        end
        return r;
    endfunction

    localparam rom_t ROM_DATA = build_rom();

    logic [SINE_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= ROM_DATA[addr];
        end
    end

    assign data = data_reg;

endmodule

[rtl/core/fcs_tone.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone channel
// Phase accumulator, quadrant folding and registered sine lookup for one tone.
// ----------------------------------------------------------------------------
module fcs_tone #(
    parameter int TABLE_BITS = 10,
    parameter int PHASE_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fcs_pkg::tone_ctrl_t     ctrl,
    input  logic [PHASE_BITS-1:0]   step,
    output fcs_pkg::sine_t          sine
);
    import fcs_pkg::*;

    localparam int QUARTER_BITS = TABLE_BITS - 2;
    localparam logic [QUARTER_BITS:0] QUARTER_LEN = {1'b1, {QUARTER_BITS{1'b0}}};

    logic [PHASE_BITS-1:0]   phase_reg;
    logic [PHASE_BITS-1:0]   phase_next;
    logic [PHASE_BITS-1:0]   phase_used;
    logic [TABLE_BITS-1:0]   table_idx;
    logic [1:0]              quad;
    logic [QUARTER_BITS:0]   pos;
    logic [QUARTER_BITS:0]   rom_addr;
    logic [SINE_W-1:0]       mag;
    logic                    neg_reg;

    // A restart makes this frame read phase zero before the phase advances.
    always_comb
    begin
        phase_used = ctrl.restart ? '0 : phase_reg;
        phase_next = phase_used + step;
        table_idx  = phase_used[PHASE_BITS-1 -: TABLE_BITS];
        quad       = table_idx[TABLE_BITS-1 -: 2];
        pos        = {1'b0, table_idx[QUARTER_BITS-1:0]};
        rom_addr   = quad[0] ? (QUARTER_LEN - pos) : pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            neg_reg <= quad[1];
        end
    end

    fcs_sine_rom #(
        .QUARTER_BITS (QUARTER_BITS)
    ) u_rom (
        .clk  (clk),
        .en   (ctrl.advance),
        .addr (rom_addr),
        .data (mag)
    );

    assign sine = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

[rtl/core/fcs_mixer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chord mixer
// Sums the four tone samples and scales the result to a quarter of full scale.
// ----------------------------------------------------------------------------
module fcs_mixer (
    input  logic                         clk,
    input  logic                         load,
    input  fcs_pkg::sine_t               sines [fcs_pkg::TONES],
    output logic [fcs_pkg::SAMPLE_W-1:0] sample
);
    import fcs_pkg::*;

    logic signed [SUM_W-1:0] sum;
    logic [SAMPLE_W-1:0]     sample_reg;
    logic [SAMPLE_W-1:0]     sample_next;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < TONES; i++)
        begin
            sum = sum + SUM_W'(sines[i]);
        end
        // Dropping the two low bits is an arithmetic shift that rounds down.
        sample_next = sum[SUM_W-1 -: SAMPLE_W];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

endmodule

[sim/chord_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chord synthesizer frame checker
// Watches the configuration, input and output channels of the chord
// synthesizer. It keeps its own tuning words and phases, works out the
// stereo frame for every accepted input transaction and compares each
// accepted output frame with the oldest frame still awaited.
// ----------------------------------------------------------------------------
module chord_frame_checker #(
    parameter int TABLE_BITS = 10,
    parameter int PHASE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [31:0]                         m_axis_tdata,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [fcs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fcs_pkg::STEP_W-1:0]          cfg_data,
    output int                                  mismatch_count,
    output int                                  frames_in_flight
);

    localparam int QUARTER_BITS = TABLE_BITS - 2;
    localparam int QUARTER_LEN  = 1 << QUARTER_BITS;
    localparam int RESTART_BIT  = 0;

    // pi/2 and 1.0 in Q30, and the largest Q1.15 magnitude.
    localparam longint unsigned QUARTER_TURN_RAD_Q30 = 64'd1686629713;
    localparam longint unsigned UNITY_Q30            = 64'd1 << 30;
    localparam longint unsigned PEAK_Q15             = 64'd32767;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } stereo_frame_t;

    stereo_frame_t          expected_frames [$];
    logic [PHASE_BITS-1:0]  tone_step  [fcs_pkg::TONES];
    logic [PHASE_BITS-1:0]  tone_phase [fcs_pkg::TONES];
    int unsigned            quarter_wave [0:QUARTER_LEN];

    // sin(pi/2 * pos / QUARTER_LEN) in Q1.15, from an eight-term Taylor series
    // evaluated in Horner form on Q30 integers.
    function automatic int unsigned quarter_wave_q15(input longint unsigned pos);
        longint unsigned angle;
        longint unsigned angle_sq;
        longint unsigned series;
        longint unsigned divisor;
        longint unsigned sine_q30;
        longint unsigned level;
        angle    = (pos * QUARTER_TURN_RAD_Q30) >> QUARTER_BITS;
        angle_sq = (angle * angle) >> 30;
        series   = UNITY_Q30;
        for (int k = 7; k >= 1; k--)
        begin
            divisor = longint'(2 * k) * longint'(2 * k + 1);
            series  = UNITY_Q30 - (((angle_sq * series) >> 30) / divisor);
        end
        sine_q30 = (angle * series) >> 30;
        level    = (PEAK_Q15 * sine_q30 + (UNITY_Q30 >> 1)) >> 30;
        if (level > PEAK_Q15)
        begin
            level = PEAK_Q15;
        end
        return int'(level);
    endfunction

    // Signed sine of one tone; odd quadrants read the quarter wave backward,
    // the second half-turn is negated.
    function automatic int tone_level(input logic [PHASE_BITS-1:0] phase);
        logic [TABLE_BITS-1:0] addr;
        logic [1:0]            quadrant;
        int                    pos;
        addr     = phase[PHASE_BITS-1 -: TABLE_BITS];
        quadrant = addr[TABLE_BITS-1 -: 2];
        pos      = int'(addr[QUARTER_BITS-1:0]);
        if (quadrant[0])
        begin
            pos = QUARTER_LEN - pos;
        end
        return quadrant[1] ? -int'(quarter_wave[pos]) : int'(quarter_wave[pos]);
    endfunction

    initial
    begin
        for (int pos = 0; pos <= QUARTER_LEN; pos++)
        begin
            quarter_wave[pos] = quarter_wave_q15(pos);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        stereo_frame_t seen;
        stereo_frame_t want;
        int            chord_sum;
        if (!rst_n)
        begin
            for (int k = 0; k < fcs_pkg::TONES; k++)
            begin
                tone_step[k]  = fcs_pkg::TONE_STEP_RESET[k];
                tone_phase[k] = '0;
            end
            expected_frames.delete();
            mismatch_count   = 0;
            frames_in_flight = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fcs_pkg::REG_TONE_STEP_0: tone_step[0] = cfg_data;
                    fcs_pkg::REG_TONE_STEP_1: tone_step[1] = cfg_data;
                    fcs_pkg::REG_TONE_STEP_2: tone_step[2] = cfg_data;
                    fcs_pkg::REG_TONE_STEP_3: tone_step[3] = cfg_data;
                    default: ;
                endcase
            end

            // The output side is handled first so that a frame that nobody
            // asked for is caught even when an input transaction lands on
            // the same edge.
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.left  = m_axis_tdata[15:0];
                seen.right = m_axis_tdata[31:16];
                if (expected_frames.size() == 0)
                begin
                    $display("%0t ns: unexpected frame, expected none, actual left %0d right %0d",
                             $time, seen.left, seen.right);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (seen.left !== want.left)
                    begin
                        $display("%0t ns: left_sample expected %0d, actual %0d",
                                 $time, want.left, seen.left);
                        mismatch_count++;
                    end
                    if (seen.right !== want.right)
                    begin
                        $display("%0t ns: right_sample expected %0d, actual %0d",
                                 $time, want.right, seen.right);
                        mismatch_count++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tdata[RESTART_BIT])
                begin
                    for (int k = 0; k < fcs_pkg::TONES; k++)
                    begin
                        tone_phase[k] = '0;
                    end
                end
                chord_sum = 0;
                for (int k = 0; k < fcs_pkg::TONES; k++)
                begin
                    chord_sum     += tone_level(tone_phase[k]);
                    tone_phase[k]  = tone_phase[k] + tone_step[k];
                end
                want.left  = 16'(chord_sum >>> 2);
                want.right = want.left;
                expected_frames.push_back(want);
            end
            frames_in_flight = expected_frames.size();
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chord synthesizer testbench
// Drives frame requests and tuning-word writes into the four-tone chord
// synthesizer with random gaps and back-pressure: a directed opening at the
// default, quarter-turn and extreme tuning words, then random tuning sets with
// random restarts. A frame checker beside the block predicts every frame.
// ----------------------------------------------------------------------------
module tb;

    import fcs_pkg::*;

    localparam int TABLE_BITS       = 10;
    localparam int PHASE_BITS       = 32;
    localparam int CLK_HALF_NS      = 6;
    localparam int RESET_CYCLES     = 5;
    localparam int IDLE_LIMIT       = 5000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_SETS      = 8;
    localparam int FRAMES_PER_SET   = 128;
    localparam int PRESSURE_SET     = 2;
    localparam int SETTLE_CYCLES    = 8;

    localparam logic [CFG_INDEX_W-1:0] TONE_REG [TONES] = '{
        REG_TONE_STEP_0, REG_TONE_STEP_1, REG_TONE_STEP_2, REG_TONE_STEP_3
    };
    localparam logic [CFG_INDEX_W-1:0] FIRST_SPARE_REG = REG_TONE_STEP_3 + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] LAST_SPARE_REG  = '1;

    localparam logic [STEP_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [STEP_W-1:0] HALF_TURN    = 32'h8000_0000;

    // Restart patterns of the directed part, consumed from bit 0 upward.
    localparam logic [9:0] DEFAULT_RESTARTS = 10'b0001100001;
    localparam logic [7:0] PEAK_RESTARTS    = 8'b0100_0000;
    localparam logic [5:0] EXTREME_RESTARTS = 6'b00_0001;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata;   // [0] restart
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [31:0]             m_axis_tdata;   // [15:0] left_sample, [31:16] right_sample
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [STEP_W-1:0]       cfg_data;

    int mismatch_count;
    int frames_in_flight;
    int idle_cycles;
    bit sender_bursting;
    bit long_hold_request;

    four_tone_chord_synth #(
        .TABLE_BITS (TABLE_BITS),
        .PHASE_BITS (PHASE_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    chord_frame_checker #(
        .TABLE_BITS (TABLE_BITS),
        .PHASE_BITS (PHASE_BITS)
    ) frame_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .frames_in_flight (frames_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF_NS clk = ~clk;
        end
    end

    // Mostly back-to-back, sometimes a short gap, now and then a long pause.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
        begin
            return 0;
        end
        else if (roll < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [STEP_W-1:0] random_tuning_word();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0800_0000);
            2: return $urandom_range(0, 255);
            3: return $urandom_range(0, 1) ? QUARTER_TURN : HALF_TURN;
            default: return $urandom_range(0, 1) ? '1 : '0;
        endcase
    endfunction

    // Leaves cfg_valid high so that writes can follow back to back.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [STEP_W-1:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic program_tones(input logic [STEP_W-1:0] tuning [TONES]);
        for (int k = 0; k < TONES; k++)
        begin
            write_reg(TONE_REG[k], tuning[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input logic restart_bit);
        int gap;
        gap = sender_bursting ? 0 : gap_length();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {7'd0, restart_bit};
        s_axis_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic drain_frames();
        s_axis_tvalid <= 1'b0;
        while (frames_in_flight != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin : result_sink
        int stall_left;
        int mode_left;
        bit steady;
        stall_left    = 0;
        mode_left     = 0;
        steady        = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold_request = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    steady    = ($urandom_range(0, 2) == 0);
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                if (stall_left == 0 && !steady)
                begin
                    stall_left = gap_length();
                end
                m_axis_tready <= (stall_left == 0);
                if (stall_left > 0)
                begin
                    stall_left--;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        logic [STEP_W-1:0] tuning [TONES];
        idle_cycles       = 0;
        sender_bursting   = 1'b0;
        long_hold_request = 1'b0;
        rst_n             = 1'b0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        cfg_valid         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Default chord straight out of reset, restarts at the start, twice in
        // a row, and in the middle of a run.
        for (int n = 0; n < $bits(DEFAULT_RESTARTS); n++)
        begin
            send_frame(DEFAULT_RESTARTS[n]);
        end
        drain_frames();

        // Every tone a quarter turn per frame walks the sine peaks of both
        // signs; the spare indexes are written and must change nothing.
        write_reg(FIRST_SPARE_REG, '1);
        write_reg(LAST_SPARE_REG, 32'hA5A5_5A5A);
        for (int k = 0; k < TONES; k++)
        begin
            tuning[k] = QUARTER_TURN;
        end
        program_tones(tuning);
        for (int n = 0; n < $bits(PEAK_RESTARTS); n++)
        begin
            send_frame(PEAK_RESTARTS[n]);
        end
        drain_frames();

        // Frozen, wrapping, aliased half-turn and smallest tuning words.
        tuning[0] = '0;
        tuning[1] = '1;
        tuning[2] = HALF_TURN;
        tuning[3] = 32'd1;
        program_tones(tuning);
        for (int n = 0; n < $bits(EXTREME_RESTARTS); n++)
        begin
            send_frame(EXTREME_RESTARTS[n]);
        end
        drain_frames();

        for (int set = 0; set < RANDOM_SETS; set++)
        begin
            for (int k = 0; k < TONES; k++)
            begin
                tuning[k] = random_tuning_word();
            end
            if ($urandom_range(0, 1))
            begin
                write_reg(CFG_INDEX_W'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG)),
                          $urandom);
            end
            program_tones(tuning);
            // One set runs the sender flat out against a long output stall so
            // that the block backs up into its input.
            sender_bursting = (set == PRESSURE_SET) || ($urandom_range(0, 3) == 0);
            if (set == PRESSURE_SET)
            begin
                long_hold_request = 1'b1;
            end
            for (int n = 0; n < FRAMES_PER_SET; n++)
            begin
                send_frame($urandom_range(0, 15) == 0);
            end
            drain_frames();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
